@@ rtl/assert_macros.svh @@
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define AID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define AID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aid_pkg.sv @@
// Shared types, constants and decode functions of the instruction decoder.
package aid_pkg;

    // Opcodes
    localparam logic [4:0] OP_LIVE  = 5'd1;
    localparam logic [4:0] OP_LD    = 5'd2;
    localparam logic [4:0] OP_ST    = 5'd3;
    localparam logic [4:0] OP_ADD   = 5'd4;
    localparam logic [4:0] OP_SUB   = 5'd5;
    localparam logic [4:0] OP_AND   = 5'd6;
    localparam logic [4:0] OP_OR    = 5'd7;
    localparam logic [4:0] OP_XOR   = 5'd8;
    localparam logic [4:0] OP_ZJMP  = 5'd9;
    localparam logic [4:0] OP_LDI   = 5'd10;
    localparam logic [4:0] OP_STI   = 5'd11;
    localparam logic [4:0] OP_FORK  = 5'd12;
    localparam logic [4:0] OP_LLD   = 5'd13;
    localparam logic [4:0] OP_LLDI  = 5'd14;
    localparam logic [4:0] OP_LFORK = 5'd15;
    localparam logic [4:0] OP_AFF   = 5'd16;
    localparam logic [7:0] OP_MAX   = 8'd16;
    localparam logic [7:0] OP_NONE  = 8'd0;

    // Legal coding bytes, named by argument kinds (R reg, D direct, I indirect)
    localparam logic [7:0] CB_R   = 8'h40;
    localparam logic [7:0] CB_RR  = 8'h50;
    localparam logic [7:0] CB_RI  = 8'h70;
    localparam logic [7:0] CB_DR  = 8'h90;
    localparam logic [7:0] CB_IR  = 8'hd0;
    localparam logic [7:0] CB_RRR = 8'h54;
    localparam logic [7:0] CB_RDR = 8'h64;
    localparam logic [7:0] CB_RIR = 8'h74;
    localparam logic [7:0] CB_DRR = 8'h94;
    localparam logic [7:0] CB_IRR = 8'hd4;
    localparam logic [7:0] CB_DDR = 8'ha4;
    localparam logic [7:0] CB_DIR = 8'hb4;
    localparam logic [7:0] CB_IDR = 8'he4;
    localparam logic [7:0] CB_IIR = 8'hf4;
    localparam logic [7:0] CB_RRD = 8'h58;
    localparam logic [7:0] CB_RDD = 8'h68;
    localparam logic [7:0] CB_RID = 8'h78;

    // Argument types
    localparam logic [1:0] ARG_NONE = 2'd0;
    localparam logic [1:0] ARG_REG  = 2'd1;
    localparam logic [1:0] ARG_DIR  = 2'd2;
    localparam logic [1:0] ARG_IND  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_OP     = 2'd1;
    localparam logic [1:0] ST_BAD_CODING = 2'd2;

    localparam int NUM_ARGS = 3;

    typedef enum logic [1:0] {
        TK_START,
        TK_CODING,
        TK_ARG
    } t_tok_kind;

    // One classified byte passed from the front to the back
    typedef struct packed {
        t_tok_kind                 kind;
        logic [7:0]                data;
        logic [NUM_ARGS-1:0][1:0]  types;
        logic [1:0]                slot;
        logic                      emit;
        logic [1:0]                status;
        logic [3:0]                length;
    } t_token;

    function automatic logic short_direct(input logic [4:0] op);
        return ((op >= OP_ZJMP) && (op <= OP_FORK)) || (op == OP_LLDI) || (op == OP_LFORK);
    endfunction

    function automatic logic no_coding(input logic [4:0] op);
        return (op == OP_LIVE) || (op == OP_ZJMP) || (op == OP_FORK) || (op == OP_LFORK);
    endfunction

    function automatic logic coding_legal(input logic [4:0] op, input logic [7:0] c);
        logic ok;
        case (op)
            OP_LD, OP_LLD: begin
                ok = (c == CB_DR) || (c == CB_IR);
            end
            OP_ST: begin
                ok = (c == CB_RR) || (c == CB_RI);
            end
            OP_ADD, OP_SUB: begin
                ok = (c == CB_RRR);
            end
            OP_AND, OP_OR, OP_XOR: begin
                ok = (c == CB_RRR) || (c == CB_RDR) || (c == CB_RIR) || (c == CB_DRR) ||
                     (c == CB_IRR) || (c == CB_DDR) || (c == CB_DIR) || (c == CB_IDR) ||
                     (c == CB_IIR);
            end
            OP_LDI, OP_LLDI: begin
                ok = (c == CB_RRR) || (c == CB_DDR) || (c == CB_RDR) || (c == CB_DRR) ||
                     (c == CB_IRR) || (c == CB_IDR);
            end
            OP_STI: begin
                ok = (c == CB_RRR) || (c == CB_RRD) || (c == CB_RDR) || (c == CB_RDD) ||
                     (c == CB_RIR) || (c == CB_RID);
            end
            OP_AFF: begin
                ok = (c == CB_R);
            end
            default: begin
                ok = 1'b1;
            end
        endcase
        return ok;
    endfunction

    // Bytes taken by one argument of the given type
    function automatic logic [2:0] arg_size(input logic [1:0] t, input logic [4:0] op);
        logic [2:0] n;
        case (t)
            ARG_REG: n = 3'd1;
            ARG_IND: n = 3'd2;
            ARG_DIR: n = short_direct(op) ? 3'd2 : 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

@@ rtl/arena_instruction_decoder.sv @@
// Top level of the instruction decoder: classifying front, token queue and assembling back.
// After its last byte is taken, a result passes the queue stage, then the result register.
// Throughput: one code byte per cycle unless stalled; results load as old ones are taken.
// The front stalls only when the token queue (QUEUE_DEPTH entries) is full.
// The back holds a finished result while the output side stalls and keeps assembling others.
// Reset (synchronous, active low) returns to awaiting an opcode and empties queue and output.
module arena_instruction_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_code_byte,
    input  logic        i_first,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_opcode,
    output logic [7:0]  o_coding_byte,
    output logic [1:0]  o_first_type,
    output logic [31:0] o_first_value,
    output logic [1:0]  o_second_type,
    output logic [31:0] o_second_value,
    output logic [1:0]  o_third_type,
    output logic [31:0] o_third_value,
    output logic [3:0]  o_length,
    output logic [1:0]  o_status
);

    logic            q_full;
    logic            q_push;
    logic            q_valid;
    logic            q_pop;
    aid_pkg::t_token push_token;
    aid_pkg::t_token head_token;

    aid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_code_byte (i_code_byte),
        .i_first     (i_first),
        .i_q_full    (q_full),
        .o_stall     (o_stall),
        .o_push      (q_push),
        .o_token     (push_token)
    );

    aid_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_token (push_token),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_token (head_token),
        .o_full  (q_full)
    );

    aid_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_token        (head_token),
        .o_pop          (q_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_opcode       (o_opcode),
        .o_coding_byte  (o_coding_byte),
        .o_first_type   (o_first_type),
        .o_first_value  (o_first_value),
        .o_second_type  (o_second_type),
        .o_second_value (o_second_value),
        .o_third_type   (o_third_type),
        .o_third_value  (o_third_value),
        .o_length       (o_length),
        .o_status       (o_status)
    );

endmodule

@@ rtl/aid_front.sv @@
// Front end: accepts code bytes, tracks instruction phase and classifies each byte.
`include "assert_macros.svh"

module aid_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_code_byte,
    input  logic            i_first,
    input  logic            i_q_full,
    output logic            o_stall,
    output logic            o_push,
    output aid_pkg::t_token o_token
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CODING,
        PH_ARGS
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [4:0]                       r_opcode, n_opcode;
    logic [aid_pkg::NUM_ARGS-1:0][1:0] r_types, n_types;
    logic [1:0]                       r_slot, n_slot;
    logic [2:0]                       r_left, n_left;
    logic [3:0]                       r_count, n_count;

    logic                             accept;
    logic [aid_pkg::NUM_ARGS-1:0][1:0] c_types;
    logic                             c_found;
    logic [1:0]                       c_slot;
    logic [2:0]                       c_size;
    logic                             a_found;
    logic [1:0]                       a_slot;
    logic [2:0]                       a_size;
    logic [2:0]                       left_dec;
    logic [3:0]                       count_inc;

    assign o_stall   = i_q_full;
    assign accept    = i_valid && !i_q_full;
    assign left_dec  = (r_left != 3'd0) ? (r_left - 3'd1) : 3'd0;
    assign count_inc = r_count + 4'd1;

    // Split the coding byte into argument types, top pair first
    assign c_types[0] = i_code_byte[7:6];
    assign c_types[1] = i_code_byte[5:4];
    assign c_types[2] = i_code_byte[3:2];

    // Find the first argument with bytes in the new coding byte
    always_comb begin
        c_found = 1'b0;
        c_slot  = 2'd0;
        c_size  = 3'd0;
        for (int k = aid_pkg::NUM_ARGS - 1; k >= 0; k--) begin
            if (aid_pkg::arg_size(c_types[k], r_opcode) != 3'd0) begin
                c_found = 1'b1;
                c_slot  = 2'(k);
                c_size  = aid_pkg::arg_size(c_types[k], r_opcode);
            end
        end
    end

    // Find the next argument with bytes after the current slot
    always_comb begin
        a_found = 1'b0;
        a_slot  = 2'd0;
        a_size  = 3'd0;
        for (int k = aid_pkg::NUM_ARGS - 1; k >= 0; k--) begin
            if ((2'(k) > r_slot) && (aid_pkg::arg_size(r_types[k], r_opcode) != 3'd0)) begin
                a_found = 1'b1;
                a_slot  = 2'(k);
                a_size  = aid_pkg::arg_size(r_types[k], r_opcode);
            end
        end
    end

    // Classify the accepted byte and advance the phase
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_types  = r_types;
        n_slot   = r_slot;
        n_left   = r_left;
        n_count  = r_count;
        o_push   = 1'b0;
        o_token.kind   = aid_pkg::TK_ARG;
        o_token.data   = i_code_byte;
        o_token.types  = '0;
        o_token.slot   = r_slot;
        o_token.emit   = 1'b0;
        o_token.status = aid_pkg::ST_OK;
        o_token.length = 4'd0;
        if (accept) begin
            if (i_first) begin
                o_push       = 1'b1;
                o_token.kind = aid_pkg::TK_START;
                n_types      = '0;
                n_slot       = 2'd0;
                n_left       = 3'd0;
                if ((i_code_byte == aid_pkg::OP_NONE) || (i_code_byte > aid_pkg::OP_MAX)) begin
                    o_token.emit   = 1'b1;
                    o_token.status = aid_pkg::ST_BAD_OP;
                    o_token.length = 4'd1;
                    n_phase        = PH_IDLE;
                    n_opcode       = 5'd0;
                    n_count        = 4'd0;
                end else begin
                    n_opcode = i_code_byte[4:0];
                    n_count  = 4'd1;
                    if (aid_pkg::no_coding(i_code_byte[4:0])) begin
                        n_types[0]    = aid_pkg::ARG_DIR;
                        n_left        = aid_pkg::arg_size(aid_pkg::ARG_DIR, i_code_byte[4:0]);
                        o_token.types = n_types;
                        n_phase       = PH_ARGS;
                    end else begin
                        n_phase = PH_CODING;
                    end
                end
            end else begin
                case (r_phase)
                    PH_CODING: begin
                        o_push       = 1'b1;
                        o_token.kind = aid_pkg::TK_CODING;
                        n_count      = 4'd2;
                        if (!aid_pkg::coding_legal(r_opcode, i_code_byte)) begin
                            o_token.emit   = 1'b1;
                            o_token.status = aid_pkg::ST_BAD_CODING;
                            o_token.length = 4'd2;
                            n_phase        = PH_IDLE;
                        end else begin
                            o_token.types = c_types;
                            n_types       = c_types;
                            if (c_found) begin
                                n_slot  = c_slot;
                                n_left  = c_size;
                                n_phase = PH_ARGS;
                            end else begin
                                o_token.emit   = 1'b1;
                                o_token.length = 4'd2;
                                n_phase        = PH_IDLE;
                            end
                        end
                    end
                    PH_ARGS: begin
                        o_push  = 1'b1;
                        n_count = count_inc;
                        n_left  = left_dec;
                        if (left_dec == 3'd0) begin
                            if (a_found) begin
                                n_slot = a_slot;
                                n_left = a_size;
                            end else begin
                                o_token.emit   = 1'b1;
                                o_token.length = count_inc;
                                n_phase        = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        // drop a stray byte outside an instruction
                    end
                endcase
            end
        end
    end

    // Hold phase and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_opcode <= 5'd0;
            r_types  <= '0;
            r_slot   <= 2'd0;
            r_left   <= 3'd0;
            r_count  <= 4'd0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_types  <= n_types;
            r_slot   <= n_slot;
            r_left   <= n_left;
            r_count  <= n_count;
        end
    end

    `AID_ASSERT(a_args_pending, (r_phase == PH_ARGS) |-> ((r_left != 3'd0) && (r_slot != 2'd3)), "argument phase without pending bytes")
    `AID_ASSERT(a_push_on_accept, o_push |-> accept, "token pushed without an accepted byte")

endmodule

@@ rtl/aid_queue.sv @@
// Short token queue between the decoder front and back.
`include "assert_macros.svh"

module aid_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aid_pkg::t_token i_token,
    input  logic            i_pop,
    output logic            o_valid,
    output aid_pkg::t_token o_token,
    output logic            o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aid_pkg::t_token  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : (r_wr_ptr + PTR_W'(1));
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : (r_rd_ptr + PTR_W'(1));
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed token
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    `AID_ASSERT(a_no_push_full, i_push |-> !o_full, "push into a full queue")
    `AID_ASSERT(a_count_bound, r_count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

@@ rtl/aid_back.sv @@
// Back end: assembles arguments from tokens and holds the result register.
`include "assert_macros.svh"

module aid_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  aid_pkg::t_token i_token,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_opcode,
    output logic [7:0]      o_coding_byte,
    output logic [1:0]      o_first_type,
    output logic [31:0]     o_first_value,
    output logic [1:0]      o_second_type,
    output logic [31:0]     o_second_value,
    output logic [1:0]      o_third_type,
    output logic [31:0]     o_third_value,
    output logic [3:0]      o_length,
    output logic [1:0]      o_status
);

    logic [7:0]                         r_opcode, n_opcode;
    logic [7:0]                         r_coding, n_coding;
    logic [aid_pkg::NUM_ARGS-1:0][1:0]  r_types, n_types;
    logic [aid_pkg::NUM_ARGS-1:0][31:0] r_values, n_values;

    logic                               r_o_valid;
    logic [7:0]                         r_o_opcode;
    logic [7:0]                         r_o_coding;
    logic [aid_pkg::NUM_ARGS-1:0][1:0]  r_o_types;
    logic [aid_pkg::NUM_ARGS-1:0][31:0] r_o_values;
    logic [3:0]                         r_o_length;
    logic [1:0]                         r_o_status;

    // Take a token unless it would overwrite a result still waiting
    assign o_pop = i_q_valid && (!i_token.emit || !r_o_valid || !i_stall);

    // Apply the token to the instruction being assembled
    always_comb begin
        n_opcode = r_opcode;
        n_coding = r_coding;
        n_types  = r_types;
        n_values = r_values;
        if (o_pop) begin
            case (i_token.kind)
                aid_pkg::TK_START: begin
                    n_opcode = i_token.data;
                    n_coding = 8'd0;
                    n_types  = i_token.types;
                    n_values = '0;
                end
                aid_pkg::TK_CODING: begin
                    n_coding = i_token.data;
                    n_types  = i_token.types;
                end
                aid_pkg::TK_ARG: begin
                    for (int k = 0; k < aid_pkg::NUM_ARGS; k++) begin
                        if (i_token.slot == 2'(k)) begin
                            n_values[k] = {r_values[k][23:0], i_token.data};
                        end
                    end
                end
                default: begin
                    // leave state unchanged
                end
            endcase
        end
    end

    // Hold the working instruction
    always_ff @(posedge i_clk) begin
        r_opcode <= n_opcode;
        r_coding <= n_coding;
        r_types  <= n_types;
        r_values <= n_values;
    end

    // Hold the result valid until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_pop && i_token.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    // Load the result payload on a finishing token
    always_ff @(posedge i_clk) begin
        if (o_pop && i_token.emit) begin
            r_o_opcode <= n_opcode;
            r_o_coding <= n_coding;
            r_o_types  <= n_types;
            r_o_values <= n_values;
            r_o_length <= i_token.length;
            r_o_status <= i_token.status;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_opcode       = r_o_opcode;
    assign o_coding_byte  = r_o_coding;
    assign o_first_type   = r_o_types[0];
    assign o_first_value  = r_o_values[0];
    assign o_second_type  = r_o_types[1];
    assign o_second_value = r_o_values[1];
    assign o_third_type   = r_o_types[2];
    assign o_third_value  = r_o_values[2];
    assign o_length       = r_o_length;
    assign o_status       = r_o_status;

    `AID_ASSERT_NEXT(a_emit_shows, o_pop && i_token.emit, r_o_valid, "finished item not shown")
    `AID_ASSERT(a_no_overwrite, (r_o_valid && i_stall) |-> !(o_pop && i_token.emit), "waiting result overwritten")

endmodule

@@ verif/tb_arena_instruction_decoder.sv @@
// Self-checking testbench for the arena instruction decoder: byte stream in, decoded items out.
module tb_arena_instruction_decoder;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    // Legal coding bytes, drawn from when a well-formed instruction is built
    localparam logic [7:0] CODING_MENU [17] = '{
        aid_pkg::CB_R, aid_pkg::CB_RR, aid_pkg::CB_RI, aid_pkg::CB_DR, aid_pkg::CB_IR,
        aid_pkg::CB_RRR, aid_pkg::CB_RDR, aid_pkg::CB_RIR, aid_pkg::CB_DRR,
        aid_pkg::CB_IRR, aid_pkg::CB_DDR, aid_pkg::CB_DIR, aid_pkg::CB_IDR,
        aid_pkg::CB_IIR, aid_pkg::CB_RRD, aid_pkg::CB_RDD, aid_pkg::CB_RID
    };

    // Coding byte used per opcode in the directed part (zero where none is taken)
    localparam logic [7:0] DIRECTED_CODING [17] = '{
        8'h00, 8'h00, aid_pkg::CB_DR, aid_pkg::CB_RI, aid_pkg::CB_RRR, aid_pkg::CB_RRR,
        aid_pkg::CB_DDR, aid_pkg::CB_IIR, aid_pkg::CB_DIR, 8'h00, aid_pkg::CB_IDR,
        aid_pkg::CB_RDD, 8'h00, aid_pkg::CB_IR, aid_pkg::CB_DDR, 8'h00, aid_pkg::CB_R
    };

    typedef enum logic [1:0] {
        WAIT_OPCODE,
        WAIT_CODING,
        WAIT_ARGS
    } t_decode_phase;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  coding_byte;
        logic [1:0]  first_type;
        logic [31:0] first_value;
        logic [1:0]  second_type;
        logic [31:0] second_value;
        logic [1:0]  third_type;
        logic [31:0] third_value;
        logic [3:0]  length;
        logic [1:0]  status;
    } t_decoded_instr;

    // Decode predictor and store of decoded instructions still to arrive
    class t_instr_decode_checker;
        t_decode_phase  phase;
        logic [7:0]     held_op;
        logic [7:0]     held_coding;
        logic [1:0]     arg_kind [3];
        logic [31:0]    arg_value [3];
        int             arg_index;
        int             arg_bytes_left;
        logic [3:0]     bytes_taken;
        t_decoded_instr expected_decodes [$];
        int             mismatches;
        int             decodes_checked;
        int             status_count [4];

        function new();
            phase           = WAIT_OPCODE;
            held_op         = '0;
            held_coding     = '0;
            bytes_taken     = '0;
            mismatches      = 0;
            decodes_checked = 0;
            foreach (status_count[k]) status_count[k] = 0;
            clear_args();
        endfunction

        function bit direct_is_short(logic [7:0] op);
            return (op >= aid_pkg::OP_ZJMP && op <= aid_pkg::OP_FORK) ||
                   op == aid_pkg::OP_LLDI || op == aid_pkg::OP_LFORK;
        endfunction

        function bit lacks_coding(logic [7:0] op);
            return op == aid_pkg::OP_LIVE || op == aid_pkg::OP_ZJMP ||
                   op == aid_pkg::OP_FORK || op == aid_pkg::OP_LFORK;
        endfunction

        function bit coding_ok(logic [7:0] op, logic [7:0] c);
            case (op)
                aid_pkg::OP_LD, aid_pkg::OP_LLD:
                    return c inside {aid_pkg::CB_DR, aid_pkg::CB_IR};
                aid_pkg::OP_ST:
                    return c inside {aid_pkg::CB_RR, aid_pkg::CB_RI};
                aid_pkg::OP_ADD, aid_pkg::OP_SUB:
                    return c == aid_pkg::CB_RRR;
                aid_pkg::OP_AND, aid_pkg::OP_OR, aid_pkg::OP_XOR:
                    return c inside {aid_pkg::CB_RRR, aid_pkg::CB_RDR, aid_pkg::CB_RIR,
                                     aid_pkg::CB_DRR, aid_pkg::CB_IRR, aid_pkg::CB_DDR,
                                     aid_pkg::CB_DIR, aid_pkg::CB_IDR, aid_pkg::CB_IIR};
                aid_pkg::OP_LDI, aid_pkg::OP_LLDI:
                    return c inside {aid_pkg::CB_RRR, aid_pkg::CB_DDR, aid_pkg::CB_RDR,
                                     aid_pkg::CB_DRR, aid_pkg::CB_IRR, aid_pkg::CB_IDR};
                aid_pkg::OP_STI:
                    return c inside {aid_pkg::CB_RRR, aid_pkg::CB_RRD, aid_pkg::CB_RDR,
                                     aid_pkg::CB_RDD, aid_pkg::CB_RIR, aid_pkg::CB_RID};
                aid_pkg::OP_AFF:
                    return c == aid_pkg::CB_R;
                default:
                    return 1'b1;
            endcase
        endfunction

        function int arg_bytes(logic [1:0] kind, logic [7:0] op);
            case (kind)
                aid_pkg::ARG_REG: return 1;
                aid_pkg::ARG_IND: return 2;
                aid_pkg::ARG_DIR: return direct_is_short(op) ? 2 : 4;
                default:          return 0;
            endcase
        endfunction

        function void clear_args();
            foreach (arg_kind[k]) begin
                arg_kind[k]  = aid_pkg::ARG_NONE;
                arg_value[k] = '0;
            end
            arg_index      = 0;
            arg_bytes_left = 0;
        endfunction

        // Advance to the next argument at or after from that takes bytes
        function bit seek_slot(int from);
            int n;
            for (int k = from; k < 3; k++) begin
                n = arg_bytes(arg_kind[k], held_op);
                if (n != 0) begin
                    arg_index      = k;
                    arg_bytes_left = n;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void queue_decode(logic [7:0] op, logic [7:0] coding, logic [3:0] len,
                                   logic [1:0] status);
            t_decoded_instr d;
            d.opcode       = op;
            d.coding_byte  = coding;
            d.first_type   = arg_kind[0];
            d.first_value  = arg_value[0];
            d.second_type  = arg_kind[1];
            d.second_value = arg_value[1];
            d.third_type   = arg_kind[2];
            d.third_value  = arg_value[2];
            d.length       = len;
            d.status       = status;
            expected_decodes.push_back(d);
        endfunction

        // Note one accepted code byte and queue the decode it completes, if any
        function void take_byte(logic [7:0] b, logic f);
            if (f) begin
                clear_args();
                held_coding = '0;
                if (b == aid_pkg::OP_NONE || b > aid_pkg::OP_MAX) begin
                    held_op     = '0;
                    bytes_taken = '0;
                    phase       = WAIT_OPCODE;
                    queue_decode(b, 8'h00, 4'd1, aid_pkg::ST_BAD_OP);
                    return;
                end
                held_op     = b;
                bytes_taken = 4'd1;
                if (lacks_coding(b)) begin
                    arg_kind[0] = aid_pkg::ARG_DIR;
                    void'(seek_slot(0));
                    phase = WAIT_ARGS;
                end else begin
                    phase = WAIT_CODING;
                end
                return;
            end
            case (phase)
                WAIT_CODING: begin
                    held_coding = b;
                    bytes_taken = 4'd2;
                    if (!coding_ok(held_op, b)) begin
                        phase = WAIT_OPCODE;
                        queue_decode(held_op, b, 4'd2, aid_pkg::ST_BAD_CODING);
                    end else begin
                        arg_kind[0] = b[7:6];
                        arg_kind[1] = b[5:4];
                        arg_kind[2] = b[3:2];
                        if (seek_slot(0)) begin
                            phase = WAIT_ARGS;
                        end else begin
                            phase = WAIT_OPCODE;
                            queue_decode(held_op, held_coding, bytes_taken, aid_pkg::ST_OK);
                        end
                    end
                end
                WAIT_ARGS: begin
                    arg_value[arg_index] = {arg_value[arg_index][23:0], b};
                    bytes_taken = bytes_taken + 4'd1;
                    if (arg_bytes_left > 0) arg_bytes_left--;
                    if (arg_bytes_left == 0 && !seek_slot(arg_index + 1)) begin
                        phase = WAIT_OPCODE;
                        queue_decode(held_op, held_coding, bytes_taken, aid_pkg::ST_OK);
                    end
                end
                default: begin
                    // drop stray bytes between instructions
                end
            endcase
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] seen);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: %s expected 0x%0h got 0x%0h", what, want, seen);
        endfunction

        // Compare one decoded item from the block with the oldest pending decode
        function void match_decode(t_decoded_instr got);
            t_decoded_instr want;
            if (expected_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: decode with opcode 0x%0h arrived with none pending",
                             got.opcode);
                return;
            end
            want = expected_decodes.pop_front();
            if (want.opcode !== got.opcode)
                flag("opcode", 32'(want.opcode), 32'(got.opcode));
            if (want.coding_byte !== got.coding_byte)
                flag("coding_byte", 32'(want.coding_byte), 32'(got.coding_byte));
            if (want.first_type !== got.first_type)
                flag("first_type", 32'(want.first_type), 32'(got.first_type));
            if (want.first_value !== got.first_value)
                flag("first_value", want.first_value, got.first_value);
            if (want.second_type !== got.second_type)
                flag("second_type", 32'(want.second_type), 32'(got.second_type));
            if (want.second_value !== got.second_value)
                flag("second_value", want.second_value, got.second_value);
            if (want.third_type !== got.third_type)
                flag("third_type", 32'(want.third_type), 32'(got.third_type));
            if (want.third_value !== got.third_value)
                flag("third_value", want.third_value, got.third_value);
            if (want.length !== got.length)
                flag("length", 32'(want.length), 32'(got.length));
            if (want.status !== got.status)
                flag("status", 32'(want.status), 32'(got.status));
            status_count[want.status]++;
            decodes_checked++;
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_code_byte = 8'h00;
    logic        i_first     = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_opcode;
    logic [7:0]  o_coding_byte;
    logic [1:0]  o_first_type;
    logic [31:0] o_first_value;
    logic [1:0]  o_second_type;
    logic [31:0] o_second_value;
    logic [1:0]  o_third_type;
    logic [31:0] o_third_value;
    logic [3:0]  o_length;
    logic [1:0]  o_status;

    t_instr_decode_checker decoder_sb = new();
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request   = 1'b0;
    int bytes_driven   = 0;
    int quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    arena_instruction_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_byte    (i_code_byte),
        .i_first        (i_first),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_opcode       (o_opcode),
        .o_coding_byte  (o_coding_byte),
        .o_first_type   (o_first_type),
        .o_first_value  (o_first_value),
        .o_second_type  (o_second_type),
        .o_second_value (o_second_value),
        .o_third_type   (o_third_type),
        .o_third_value  (o_third_value),
        .o_length       (o_length),
        .o_status       (o_status)
    );

    // Offer one code byte, after a random gap when the sender idles, and hold it until taken
    task automatic drive_byte(input logic [7:0] b, input logic f);
        int gap;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_byte <= b;
        i_first     <= f;
        do @(posedge i_clk); while (o_stall);
        decoder_sb.take_byte(b, f);
        bytes_driven++;
    endtask

    // Send an instruction; fill picks random, all-zero or all-one argument bytes,
    // and cut stops it after that many bytes
    task automatic send_instruction(input logic [7:0] op, input logic [7:0] coding,
                                    input int fill, input int cut);
        logic [1:0] kinds [3];
        logic [7:0] arg;
        int         n;
        int         sent;
        drive_byte(op, 1'b1);
        sent = 1;
        if (op == aid_pkg::OP_NONE || op > aid_pkg::OP_MAX) return;
        if (decoder_sb.lacks_coding(op)) begin
            kinds[0] = aid_pkg::ARG_DIR;
            kinds[1] = aid_pkg::ARG_NONE;
            kinds[2] = aid_pkg::ARG_NONE;
        end else begin
            if (sent >= cut) return;
            drive_byte(coding, 1'b0);
            sent++;
            if (!decoder_sb.coding_ok(op, coding)) return;
            kinds[0] = coding[7:6];
            kinds[1] = coding[5:4];
            kinds[2] = coding[3:2];
        end
        for (int k = 0; k < 3; k++) begin
            n = decoder_sb.arg_bytes(kinds[k], op);
            for (int j = 0; j < n; j++) begin
                if (sent >= cut) return;
                arg = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom_range(0, 255));
                drive_byte(arg, 1'b0);
                sent++;
            end
        end
    endtask

    function automatic logic [7:0] legal_coding(input logic [7:0] op);
        logic [7:0] c;
        do c = CODING_MENU[$urandom_range(0, 16)]; while (!decoder_sb.coding_ok(op, c));
        return c;
    endfunction

    // Mostly well-formed instructions, with bad opcodes, bad codings, cut-offs and strays
    task automatic random_instruction();
        int         pick;
        logic [7:0] op;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        op   = 8'($urandom_range(1, 16));
        if (pick < 70) begin
            send_instruction(op, legal_coding(op), 0, 99);
        end else if (pick < 78) begin
            op = ($urandom_range(0, 3) == 0) ? aid_pkg::OP_NONE : 8'($urandom_range(17, 255));
            send_instruction(op, 8'h00, 0, 99);
        end else if (pick < 86) begin
            while (decoder_sb.lacks_coding(op)) op = 8'($urandom_range(1, 16));
            do c = 8'($urandom_range(0, 255)); while (decoder_sb.coding_ok(op, c));
            send_instruction(op, c, 0, 99);
        end else if (pick < 94) begin
            send_instruction(op, legal_coding(op), 0, $urandom_range(1, 5));
        end else begin
            repeat ($urandom_range(1, 3)) drive_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Stop offering and wait until every pending decode has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (decoder_sb.expected_decodes.size() != 0);
    endtask

    // Take decoded items, stalling before each for a random hold while the receiver idles or a long one on request
    initial begin
        t_decoded_instr seen;
        int             hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                hold = receiver_idles ? $urandom_range(0, 5) : 0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            seen.opcode       = o_opcode;
            seen.coding_byte  = o_coding_byte;
            seen.first_type   = o_first_type;
            seen.first_value  = o_first_value;
            seen.second_type  = o_second_type;
            seen.second_value = o_second_value;
            seen.third_type   = o_third_type;
            seen.third_value  = o_third_value;
            seen.length       = o_length;
            seen.status       = o_status;
            decoder_sb.match_decode(seen);
        end
    end

    // End the run when no handshake happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad opcodes, every opcode with extreme arguments, bad codings,
        // a stray byte and restarts in the middle of an instruction
        send_instruction(aid_pkg::OP_NONE, 8'h00, 0, 99);
        send_instruction(8'd17, 8'h00, 0, 99);
        send_instruction(8'hff, 8'h00, 0, 99);
        for (int op = 1; op <= 16; op++)
            send_instruction(8'(op), DIRECTED_CODING[op], (op % 2) ? 1 : 2, 99);
        send_instruction(8'(aid_pkg::OP_LD), 8'h00, 0, 99);
        send_instruction(8'(aid_pkg::OP_AFF), 8'hff, 0, 99);
        drive_byte(8'h5a, 1'b0);
        send_instruction(8'(aid_pkg::OP_AND), aid_pkg::CB_DDR, 0, 4);
        send_instruction(8'(aid_pkg::OP_SUB), aid_pkg::CB_RRR, 0, 1);
        send_instruction(8'(aid_pkg::OP_ST), aid_pkg::CB_RR, 0, 99);
        wait_drained();

        // Burst with a long output hold so the block backs up
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_request   = 1'b1;
        while (bytes_driven < 200) random_instruction();
        wait_drained();

        // Steady input against a stalling output, then idling on both sides
        receiver_idles = 1'b1;
        while (bytes_driven < 300) random_instruction();
        sender_idles = 1'b1;
        while (bytes_driven < 400) random_instruction();

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d code bytes and %0d decodes: %0d good, %0d bad opcode,",
                 bytes_driven, decoder_sb.decodes_checked,
                 decoder_sb.status_count[aid_pkg::ST_OK],
                 decoder_sb.status_count[aid_pkg::ST_BAD_OP]);
        $display("%0d bad coding, with restarts, strays and a long output hold",
                 decoder_sb.status_count[aid_pkg::ST_BAD_CODING]);
        if (decoder_sb.mismatches == 0 && decoder_sb.expected_decodes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d field mismatches, %0d decodes never arrived",
                     decoder_sb.mismatches, decoder_sb.expected_decodes.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/aid_pkg.sv
rtl/aid_front.sv
rtl/aid_queue.sv
rtl/aid_back.sv
rtl/arena_instruction_decoder.sv
verif/tb_arena_instruction_decoder.sv
